>>> rtl/linear_probe_hash_map_top_defines.svh
// Assertion macros used by the hash map controller RTL.
`ifndef LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LPHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define LPHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/lphm_pkg.sv
package lphm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = 8;
  localparam int LIVE_W      = 9;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_DEL,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_UPDATED,
    ST_FOUND,
    ST_NOTFOUND,
    ST_FULL,
    ST_DELETED
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic key_we;
    logic val_we;
    logic flag_we;
    logic live;
    logic tomb;
    idx_t addr;
    key_t key;
    val_t value;
  } wr_t;

  typedef struct packed {
    logic live;
    logic tomb;
    key_t key;
    val_t value;
  } rd_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   value_out;
    logic [SLOT_W-1:0]   slot_out;
    logic                slot_live;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

endpackage

>>> rtl/lphm_if.sv
interface lphm_req_if import lphm_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         op;
  logic [31:0] key_in;
  logic [31:0] value_in;
  logic [7:0]  slot_in;

  modport source (output valid, output op, output key_in, output value_in,
                  output slot_in, input ready);
  modport sink (input valid, input op, input key_in, input value_in,
                input slot_in, output ready);
endinterface

interface lphm_rsp_if import lphm_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] value_out;
  logic [7:0]  slot_out;
  logic        slot_live;
  logic [8:0]  live_count;

  modport source (output valid, output status, output value_out, output slot_out,
                  output slot_live, output live_count, input ready);
  modport sink (input valid, input status, input value_out, input slot_out,
                input slot_live, input live_count, output ready);
endinterface

>>> rtl/lphm_store.sv
module lphm_store import lphm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rd_en,
  input  idx_t rd_addr,
  input  wr_t  wr,
  output rd_t  rd
);

  logic [TABLE_DEPTH-1:0] live_mark;
  logic [TABLE_DEPTH-1:0] tomb_mark;
  key_t                   key_mem [TABLE_DEPTH];
  val_t                   val_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      live_mark <= '0;
      tomb_mark <= '0;
    end else if (wr.flag_we) begin
      live_mark[wr.addr] <= wr.live;
      tomb_mark[wr.addr] <= wr.tomb;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.val_we) begin
      val_mem[wr.addr] <= wr.value;
    end
    if (rd_en) begin
      rd.live  <= live_mark[rd_addr];
      rd.tomb  <= tomb_mark[rd_addr];
      rd.key   <= key_mem[rd_addr];
      rd.value <= val_mem[rd_addr];
    end
  end

endmodule

>>> rtl/lphm_ctrl.sv
`include "linear_probe_hash_map_top_defines.svh"

module lphm_ctrl import lphm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lphm_req_if.sink    req,
  output logic        rd_en,
  output idx_t        rd_addr,
  output wr_t         wr,
  input  rd_t         rd,
  output logic        res_valid,
  output rsp_t        res,
  input  logic        res_taken
);

  state_t            state, state_next;
  op_t               op_q, op_q_next;
  key_t              key_q, key_q_next;
  val_t              val_q, val_q_next;
  logic              oor, oor_next;
  idx_t              idx, idx_next;
  cnt_t              n, n_next;
  logic              have_free, have_free_next;
  idx_t              free_idx, free_idx_next;
  cnt_t              entry_count, entry_count_next;
  status_t           status_q, status_q_next;
  logic [DATA_W-1:0] vout, vout_next;
  logic [SLOT_W-1:0] sout, sout_next;
  logic              slive, slive_next;

  logic hit;
  logic empty;
  logic last;
  logic cand_have;
  idx_t cand_idx;
  idx_t idx_inc;

  assign hit       = rd.live && (rd.key == key_q);
  assign empty     = !rd.live && !rd.tomb;
  assign last      = (n == CNT_W'(TABLE_DEPTH - 1));
  assign cand_have = have_free || !rd.live;
  assign cand_idx  = have_free ? free_idx : idx;
  assign idx_inc   = (idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    key_q     <= key_q_next;
    val_q     <= val_q_next;
    oor       <= oor_next;
    idx       <= idx_next;
    n         <= n_next;
    have_free <= have_free_next;
    free_idx  <= free_idx_next;
    status_q  <= status_q_next;
    vout      <= vout_next;
    sout      <= sout_next;
    slive     <= slive_next;
  end

  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    key_q_next       = key_q;
    val_q_next       = val_q;
    oor_next         = oor;
    idx_next         = idx;
    n_next           = n;
    have_free_next   = have_free;
    free_idx_next    = free_idx;
    entry_count_next = entry_count;
    status_q_next    = status_q;
    vout_next        = vout;
    sout_next        = sout;
    slive_next       = slive;
    rd_en            = 1'b0;
    rd_addr          = idx;
    wr               = '0;
    wr.addr          = idx;
    wr.key           = key_q;
    wr.value         = val_q;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_q_next      = req.op;
          key_q_next     = req.key_in;
          val_q_next     = req.value_in[VALUE_WIDTH-1:0];
          oor_next       = (32'(req.slot_in) >= TABLE_DEPTH);
          idx_next       = (req.op == OP_READ) ? IDX_W'(req.slot_in)
                                               : req.key_in[IDX_W-1:0];
          n_next         = '0;
          have_free_next = 1'b0;
          state_next     = S_RD;
        end
      end
      S_RD: begin
        rd_en      = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        status_q_next = ST_NOTFOUND;
        vout_next     = '0;
        sout_next     = '0;
        slive_next    = 1'b0;
        state_next    = S_DONE;
        if (op_q == OP_READ) begin
          if (!oor) begin
            sout_next = SLOT_W'(idx);
            if (rd.live) begin
              status_q_next = ST_FOUND;
              slive_next    = 1'b1;
            end
            if (rd.live || rd.tomb) begin
              vout_next = DATA_W'(rd.value);
            end
          end
        end else if (hit) begin
          sout_next = SLOT_W'(idx);
          case (op_q)
            OP_PUT: begin
              wr.val_we     = 1'b1;
              status_q_next = ST_UPDATED;
            end
            OP_GET: begin
              vout_next     = DATA_W'(rd.value);
              status_q_next = ST_FOUND;
            end
            OP_DEL: begin
              wr.flag_we    = 1'b1;
              wr.tomb       = 1'b1;
              status_q_next = ST_DELETED;
              if (entry_count != '0) begin
                entry_count_next = entry_count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (empty || last) begin
          if (op_q == OP_PUT) begin
            if (cand_have) begin
              wr.addr          = cand_idx;
              wr.key_we        = 1'b1;
              wr.val_we        = 1'b1;
              wr.flag_we       = 1'b1;
              wr.live          = 1'b1;
              entry_count_next = entry_count + 1'b1;
              status_q_next    = ST_INSERTED;
              sout_next        = SLOT_W'(cand_idx);
            end else begin
              status_q_next = ST_FULL;
            end
          end
        end else begin
          if (op_q == OP_PUT) begin
            have_free_next = cand_have;
            free_idx_next  = cand_idx;
          end
          idx_next   = idx_inc;
          n_next     = n + 1'b1;
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (res_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req.ready      = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.status     = status_q;
  assign res.value_out  = vout;
  assign res.slot_out   = sout;
  assign res.slot_live  = slive;
  assign res.live_count = LIVE_W'(entry_count);

  `LPHM_ASSERT(a_res_hold, (res_valid && !res_taken) |=> (res_valid && $stable(status_q) && $stable(sout)), "result changed while waiting")
  `LPHM_ASSERT(a_count_quiet, (state != S_CHK) |=> $stable(entry_count), "entry count moved outside compare step")
  `LPHM_ASSERT_ALWAYS(a_probe_bound, (state == S_CHK) |-> (n < CNT_W'(TABLE_DEPTH)), "probe ran past table depth")
  `LPHM_ASSERT_ALWAYS(a_write_step, (wr.key_we || wr.val_we || wr.flag_we) |-> (state == S_CHK), "store written outside compare step")

endmodule

>>> rtl/linear_probe_hash_map_top.sv
// Only one word is in work at a time; a new word is taken while the sequencer is idle.
// Each probed slot takes a store read step (S_RD) followed by a key compare step (S_CHK).
// A probe visits 1 to 256 slots; after the last compare the result waits in S_DONE until
// the output register can take it, and the sequencer then returns to idle for the next word.
// Synchronous reset clears the live and tombstone flags, zeros the entry
// count and empties the output register; key and payload memories are not cleared.
module linear_probe_hash_map_top import lphm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lphm_req_if.sink    req,
  lphm_rsp_if.source  rsp
);

  logic rd_en;
  idx_t rd_addr;
  wr_t  wr;
  rd_t  rd;
  logic res_valid;
  rsp_t res;
  logic res_taken;
  logic out_valid;
  rsp_t out_word;

  lphm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  lphm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .rd        (rd),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  assign res_taken = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_word <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_word.status;
  assign rsp.value_out  = out_word.value_out;
  assign rsp.slot_out   = out_word.slot_out;
  assign rsp.slot_live  = out_word.slot_live;
  assign rsp.live_count = out_word.live_count;

endmodule

>>> tb/lphm_map_checker.sv
`timescale 1ns / 100ps

module lphm_map_checker import lphm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  lphm_req_if                    req,
  lphm_rsp_if                    rsp,
  output int unsigned            err_count,
  output int unsigned            pending,
  output int unsigned            checked_count,
  output int unsigned            full_seen,
  output logic [TABLE_DEPTH-1:0] slot_written
);

  logic                   slot_is_live [TABLE_DEPTH];
  logic                   slot_is_tomb [TABLE_DEPTH];
  key_t                   stored_key [TABLE_DEPTH];
  val_t                   stored_val [TABLE_DEPTH];
  cnt_t                   live_total;
  logic [TABLE_DEPTH-1:0] ever_written;
  rsp_t                   expected_replies [$];
  int unsigned            fails;
  int unsigned            checks;
  int unsigned            fulls;

  initial begin
    fails  = 0;
    checks = 0;
    fulls  = 0;
  end

  task automatic note_failure(input string msg);
    if (fails < 100) begin
      $display("[%0t] hash map check: %s", $time, msg);
    end
    fails++;
  endtask

  function automatic int find_live_slot(input key_t key);
    idx_t idx;
    int   hit;
    bit   stop;
    int   n;
    idx  = key[IDX_W-1:0];
    hit  = -1;
    stop = 1'b0;
    for (n = 0; n < TABLE_DEPTH && !stop; n++) begin
      if (slot_is_live[idx]) begin
        if (stored_key[idx] == key) begin
          hit  = int'(idx);
          stop = 1'b1;
        end
      end else if (!slot_is_tomb[idx]) begin
        stop = 1'b1;
      end
      idx = idx + 1'b1;
    end
    return hit;
  endfunction

  function automatic rsp_t predict_map_op(input op_t op, input key_t key, input val_t val,
                                          input logic [SLOT_W-1:0] slot);
    rsp_t r;
    idx_t idx;
    idx_t free_idx;
    bit   have_free;
    bit   matched;
    bit   stop;
    int   hit;
    int   n;
    r = '0;
    r.status = ST_NOTFOUND;
    case (op)
      OP_PUT: begin
        idx       = key[IDX_W-1:0];
        free_idx  = '0;
        have_free = 1'b0;
        matched   = 1'b0;
        stop      = 1'b0;
        for (n = 0; n < TABLE_DEPTH && !stop; n++) begin
          if (slot_is_live[idx]) begin
            if (stored_key[idx] == key) begin
              stored_val[idx] = val;
              r.status   = ST_UPDATED;
              r.slot_out = SLOT_W'(idx);
              matched    = 1'b1;
              stop       = 1'b1;
            end
          end else begin
            if (!have_free) begin
              have_free = 1'b1;
              free_idx  = idx;
            end
            if (!slot_is_tomb[idx]) begin
              stop = 1'b1;
            end
          end
          idx = idx + 1'b1;
        end
        if (!matched) begin
          if (have_free) begin
            slot_is_live[free_idx] = 1'b1;
            slot_is_tomb[free_idx] = 1'b0;
            stored_key[free_idx]   = key;
            stored_val[free_idx]   = val;
            ever_written[free_idx] = 1'b1;
            live_total             = live_total + 1'b1;
            r.status   = ST_INSERTED;
            r.slot_out = SLOT_W'(free_idx);
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      OP_GET: begin
        hit = find_live_slot(key);
        if (hit >= 0) begin
          r.status    = ST_FOUND;
          r.value_out = DATA_W'(stored_val[hit]);
          r.slot_out  = SLOT_W'(hit);
        end
      end
      OP_DEL: begin
        hit = find_live_slot(key);
        if (hit >= 0) begin
          slot_is_live[hit] = 1'b0;
          slot_is_tomb[hit] = 1'b1;
          if (live_total != 0) begin
            live_total = live_total - 1'b1;
          end
          r.status   = ST_DELETED;
          r.slot_out = SLOT_W'(hit);
        end
      end
      default: begin
        if (int'(slot) < TABLE_DEPTH) begin
          r.slot_out = slot;
          if (slot_is_live[slot]) begin
            r.status    = ST_FOUND;
            r.slot_live = 1'b1;
          end
          if (slot_is_live[slot] || slot_is_tomb[slot]) begin
            r.value_out = DATA_W'(stored_val[slot]);
          end
        end
      end
    endcase
    r.live_count = LIVE_W'(live_total);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   i;
    if (rst) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        slot_is_live[i] = 1'b0;
        slot_is_tomb[i] = 1'b0;
      end
      live_total   = '0;
      ever_written = '0;
      expected_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          note_failure("result word with no request waiting");
        end else begin
          want = expected_replies.pop_front();
          checks++;
          if (rsp.status !== want.status) begin
            note_failure($sformatf("status got %0d want %0d", rsp.status, want.status));
          end
          if (rsp.value_out !== want.value_out) begin
            note_failure($sformatf("value_out got %h want %h", rsp.value_out,
                                   want.value_out));
          end
          if (rsp.slot_out !== want.slot_out) begin
            note_failure($sformatf("slot_out got %0d want %0d", rsp.slot_out, want.slot_out));
          end
          if (rsp.slot_live !== want.slot_live) begin
            note_failure($sformatf("slot_live got %b want %b", rsp.slot_live,
                                   want.slot_live));
          end
          if (rsp.live_count !== want.live_count) begin
            note_failure($sformatf("live_count got %0d want %0d", rsp.live_count,
                                   want.live_count));
          end
        end
      end
      if (req.valid && req.ready) begin
        want = predict_map_op(req.op, req.key_in, req.value_in, req.slot_in);
        if (want.status == ST_FULL) begin
          fulls++;
        end
        expected_replies.push_back(want);
      end
    end
    err_count     <= fails;
    pending       <= expected_replies.size();
    checked_count <= checks;
    full_seen     <= fulls;
    slot_written  <= ever_written;
  end

endmodule

>>> tb/linear_probe_hash_map_top_test.sv
`timescale 1ns / 100ps

module linear_probe_hash_map_top_test;
  import lphm_pkg::*;

  logic clk;
  logic rst;

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  int unsigned            err_count;
  int unsigned            pending;
  int unsigned            checked_count;
  int unsigned            full_seen;
  logic [TABLE_DEPTH-1:0] slot_written;

  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 51;
  int unsigned hold_tag = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  key_t        key_pool [64];

  linear_probe_hash_map_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lphm_map_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .err_count     (err_count),
    .pending       (pending),
    .checked_count (checked_count),
    .full_seen     (full_seen),
    .slot_written  (slot_written)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // A long hold-off starts whenever the stimulus bumps hold_tag.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input op_t op, input key_t key, input logic [31:0] value,
                           input logic [7:0] slot);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.key_in   <= key;
    req_ch.value_in <= value;
    req_ch.slot_in  <= slot;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    words_sent++;
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_word();
    op_t         op;
    key_t        key;
    logic [31:0] value;
    logic [7:0]  slot;
    int unsigned pick;
    int          n;
    bit          hit;
    pick = $urandom_range(99);
    if (pick < 38) begin
      op = OP_PUT;
    end else if (pick < 68) begin
      op = OP_GET;
    end else if (pick < 85) begin
      op = OP_DEL;
    end else begin
      op = OP_READ;
    end
    if ($urandom_range(99) < 85) begin
      key = key_pool[$urandom_range(63)];
    end else begin
      key = $urandom();
    end
    pick  = $urandom_range(19);
    value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
    slot  = 8'($urandom_range(255));
    // Half of the slot reads are steered to a slot that has held an entry at some point.
    if (op == OP_READ && $urandom_range(1) == 0) begin
      hit = 1'b0;
      for (n = 0; n < TABLE_DEPTH && !hit; n++) begin
        if (slot_written[slot]) begin
          hit = 1'b1;
        end else begin
          slot = slot + 8'd1;
        end
      end
    end
    send_word(op, key, value, slot);
  endtask

  task automatic run_random_phase(input int unsigned tx, input int unsigned rx,
                                  input int count, input int hold_at);
    int i;
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_tag <= hold_tag + 1;
      end
      send_random_word();
    end
    wait_for_results();
  endtask

  initial begin
    logic [7:0] hot_home [20];
    key_t       key;
    key_t       kept_key;
    int         i;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_PUT;
    req_ch.key_in   <= '0;
    req_ch.value_in <= '0;
    req_ch.slot_in  <= '0;

    // Keys crowd onto a few home slots, including both ends, so probes collide and wrap.
    hot_home[0] = 8'd0;
    hot_home[1] = 8'd255;
    hot_home[2] = 8'd254;
    for (i = 3; i < 20; i++) begin
      hot_home[i] = 8'($urandom_range(255));
    end
    for (i = 0; i < 64; i++) begin
      key_pool[i] = {24'($urandom()), hot_home[i % 20]};
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_PUT,  32'h0000_0000, 32'h0000_0000, 8'h00);
    send_word(OP_PUT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_PUT,  32'h0000_0100, 32'h1234_5678, 8'h00);
    send_word(OP_PUT,  32'h0000_01FF, 32'hA5A5_A5A5, 8'h00);
    send_word(OP_GET,  32'h0000_01FF, 32'h0000_0000, 8'h00);
    send_word(OP_PUT,  32'h0000_0100, 32'hFFFF_FFFF, 8'h00);
    send_word(OP_GET,  32'h0000_0100, 32'h0000_0000, 8'h00);
    send_word(OP_GET,  32'h0000_0200, 32'h0000_0000, 8'h00);
    send_word(OP_DEL,  32'h0000_0000, 32'h0000_0000, 8'h00);
    send_word(OP_GET,  32'h0000_0100, 32'h0000_0000, 8'h00);
    send_word(OP_DEL,  32'h0000_0000, 32'h0000_0000, 8'h00);
    send_word(OP_READ, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_word(OP_PUT,  32'h0000_0300, 32'h5555_AAAA, 8'h00);
    send_word(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    send_word(OP_READ, 32'h0000_0000, 32'h0000_0000, 8'h02);
    send_word(OP_DEL,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
    send_word(OP_READ, 32'h0000_0000, 32'h0000_0000, 8'hFF);
    send_word(OP_GET,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
    send_word(OP_PUT,  32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
    send_word(OP_READ, 32'h0000_0000, 32'h0000_0000, 8'h01);
    send_word(OP_DEL,  32'h0000_01FF, 32'h0000_0000, 8'h00);
    send_word(OP_GET,  32'h0000_01FF, 32'h0000_0000, 8'h00);
    wait_for_results();

    run_random_phase(12, 51, 480, 150);
    run_random_phase(51, 12, 480, -1);
    run_random_phase(0, 0, 480, -1);

    // Fill every home slot so the table runs out of room.
    kept_key = '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      key = {24'($urandom()), 8'(i)};
      kept_key = key;
      send_word(OP_PUT, key, $urandom(), 8'($urandom_range(255)));
    end
    repeat (3) send_word(OP_PUT, $urandom(), $urandom(), 8'($urandom_range(255)));
    send_word(OP_GET, $urandom(), $urandom(), 8'($urandom_range(255)));
    send_word(OP_GET, kept_key, $urandom(), 8'($urandom_range(255)));
    send_word(OP_DEL, kept_key, $urandom(), 8'($urandom_range(255)));
    send_word(OP_PUT, $urandom(), 32'hFFFF_FFFF, 8'($urandom_range(255)));
    send_word(OP_PUT, $urandom(), 32'h0000_0000, 8'($urandom_range(255)));
    send_word(OP_READ, $urandom(), $urandom(), 8'd128);
    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests over directed cases, three idle patterns and a table fill;",
             words_sent);
    $display("checked %0d results, %0d of them table-full.", checked_count, full_seen);
    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> linear_probe_hash_map_top.f
+incdir+rtl
rtl/lphm_pkg.sv
rtl/lphm_if.sv
rtl/lphm_store.sv
rtl/lphm_ctrl.sv
rtl/linear_probe_hash_map_top.sv
tb/lphm_map_checker.sv
tb/linear_probe_hash_map_top_test.sv
